FILE: src/bleasf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bleasf_pkg
// Shared types, constants and the module-name prefix table for the serial
// module advertisement filter.
// ----------------------------------------------------------------------------
package bleasf_pkg;

    // Prefix table geometry
    localparam int PREFIX_COUNT   = 33;
    localparam int PREFIX_MAX_LEN = 8;
    localparam int POS_W          = $clog2(PREFIX_MAX_LEN + 1);
    localparam int IDX_W          = (PREFIX_MAX_LEN > 1) ? $clog2(PREFIX_MAX_LEN) : 1;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_UUID_A = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UUID_B = 1'd1;
    localparam logic [15:0] UUID_A_RESET = 16'hFFE0;
    localparam logic [15:0] UUID_B_RESET = 16'hFFF0;

    // AD record type codes
    localparam logic [7:0] AD_NAME_SHORT = 8'h08;
    localparam logic [7:0] AD_NAME_FULL  = 8'h09;
    localparam logic [7:0] AD_UUID16_INC = 8'h02;
    localparam logic [7:0] AD_UUID16_ALL = 8'h03;

    localparam logic [PREFIX_COUNT-1:0] ALIVE_ALL = '1;

    // One payload byte with its end marker
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } bleasf_step_t;

    // Outcome of comparing one name byte against every prefix
    typedef struct packed {
        logic [PREFIX_COUNT-1:0] alive;
        logic                    hit;
    } bleasf_name_t;

    // Prefix lengths; zero would mean an unused slot
    localparam logic [POS_W-1:0] NAME_LEN [PREFIX_COUNT] = '{
        4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
        4'd4, 4'd6, 4'd5, 4'd4, 4'd8,
        4'd5, 4'd5, 4'd5,
        4'd4, 4'd5, 4'd8, 4'd5, 4'd5, 4'd6,
        4'd4, 4'd5, 4'd6, 4'd6,
        4'd5, 4'd5, 4'd5, 4'd3, 4'd6, 4'd5, 4'd8, 4'd7
    };

    // Prefix characters as ASCII codes, padded with zero
    localparam logic [7:0] NAME_TAB [PREFIX_COUNT][PREFIX_MAX_LEN] = '{
        '{8'h48, 8'h43, 8'h2D, 8'h30, 8'h33, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h43, 8'h2D, 8'h30, 8'h34, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h43, 8'h2D, 8'h30, 8'h35, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h43, 8'h2D, 8'h30, 8'h36, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h43, 8'h2D, 8'h30, 8'h37, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h43, 8'h2D, 8'h30, 8'h38, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h43, 8'h2D, 8'h34, 8'h32, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h4D, 8'h2D, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h48, 8'h4D, 8'h53, 8'h6F, 8'h66, 8'h74, 8'h00, 8'h00},
        '{8'h53, 8'h48, 8'h2D, 8'h48, 8'h43, 8'h00, 8'h00, 8'h00},
        '{8'h43, 8'h43, 8'h34, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h42, 8'h4C, 8'h45, 8'h2D, 8'h43, 8'h43, 8'h34, 8'h31},
        '{8'h41, 8'h54, 8'h2D, 8'h30, 8'h39, 8'h00, 8'h00, 8'h00},
        '{8'h41, 8'h54, 8'h2D, 8'h30, 8'h35, 8'h00, 8'h00, 8'h00},
        '{8'h41, 8'h54, 8'h2D, 8'h31, 8'h39, 8'h00, 8'h00, 8'h00},
        '{8'h42, 8'h54, 8'h30, 8'h35, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h42, 8'h54, 8'h2D, 8'h30, 8'h35, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h4C, 8'h54, 8'h2D, 8'h42, 8'h54, 8'h30, 8'h35},
        '{8'h42, 8'h54, 8'h2D, 8'h48, 8'h43, 8'h00, 8'h00, 8'h00},
        '{8'h46, 8'h42, 8'h54, 8'h30, 8'h36, 8'h00, 8'h00, 8'h00},
        '{8'h46, 8'h42, 8'h54, 8'h2D, 8'h30, 8'h36, 8'h00, 8'h00},
        '{8'h4A, 8'h44, 8'h59, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h53, 8'h50, 8'h50, 8'h2D, 8'h43, 8'h00, 8'h00, 8'h00},
        '{8'h4C, 8'h69, 8'h6E, 8'h76, 8'h6F, 8'h72, 8'h00, 8'h00},
        '{8'h5A, 8'h53, 8'h2D, 8'h30, 8'h34, 8'h30, 8'h00, 8'h00},
        '{8'h54, 8'h42, 8'h2D, 8'h30, 8'h34, 8'h00, 8'h00, 8'h00},
        '{8'h52, 8'h46, 8'h2D, 8'h42, 8'h4D, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h58, 8'h2D, 8'h42, 8'h54, 8'h00, 8'h00, 8'h00},
        '{8'h4B, 8'h43, 8'h58, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h46, 8'h53, 8'h43, 8'h2D, 8'h42, 8'h54, 8'h00, 8'h00},
        '{8'h41, 8'h43, 8'h36, 8'h39, 8'h30, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h53, 8'h44, 8'h20, 8'h54, 8'h45, 8'h43, 8'h48},
        '{8'h42, 8'h6F, 8'h6C, 8'h75, 8'h74, 8'h65, 8'h6B, 8'h00}
    };

endpackage

FILE: src/bleasf_name_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bleasf_name_match
// Compares one name byte at a given position against every prefix in the
// table, in parallel, and reports surviving prefixes and a completed match.
// ----------------------------------------------------------------------------
module bleasf_name_match (
    input  logic [7:0]                          data_byte,
    input  logic [bleasf_pkg::POS_W-1:0]        pos,
    input  logic [bleasf_pkg::PREFIX_COUNT-1:0] alive_in,
    output bleasf_pkg::bleasf_name_t            result
);
    import bleasf_pkg::*;

    // Drop prefixes that disagree; flag one whose last character matched
    always_comb begin
        result.alive = alive_in;
        result.hit   = 1'b0;
        for (int p = 0; p < PREFIX_COUNT; p++) begin
            if (pos < NAME_LEN[p]) begin
                if (data_byte != NAME_TAB[p][pos[IDX_W-1:0]]) begin
                    result.alive[p] = 1'b0;
                end else if (pos == NAME_LEN[p] - POS_W'(1) && alive_in[p]) begin
                    result.hit = 1'b1;
                end
            end
        end
    end

endmodule

FILE: src/bleasf_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bleasf_parser
// Walks the length-type-data records of a payload one byte per step and
// produces the payload's match verdict on the final byte.
// ----------------------------------------------------------------------------
module bleasf_parser (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step_en,
    input  bleasf_pkg::bleasf_step_t step,
    input  logic [15:0]              uuid_a,
    input  logic [15:0]              uuid_b,
    output logic                     matched
);
    import bleasf_pkg::*;

    typedef enum logic [1:0] {
        PH_LEN,
        PH_TYPE,
        PH_DATA,
        PH_STOP
    } phase_t;

    typedef enum logic [1:0] {
        KIND_OTHER,
        KIND_NAME,
        KIND_UUID
    } kind_t;

    phase_t                  phase_reg, phase_next;
    kind_t                   kind_reg, kind_next;
    logic [7:0]              bytes_left_reg, bytes_left_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic                    odd_reg, odd_next;
    logic [PREFIX_COUNT-1:0] alive_reg, alive_next;
    logic [7:0]              uuid_low_reg, uuid_low_next;
    logic                    record_hit_reg, record_hit_next;
    logic                    committed_reg, committed_next;

    logic [7:0]   bytes_dec;
    logic         hit_now;
    bleasf_name_t name_res;

    bleasf_name_match u_name_match (
        .data_byte (step.data_byte),
        .pos       (pos_reg),
        .alive_in  (alive_reg),
        .result    (name_res)
    );

    assign bytes_dec = bytes_left_reg - 8'd1;

    // Advance the record walk by one byte
    always_comb begin
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        bytes_left_next = bytes_left_reg;
        pos_next        = pos_reg;
        odd_next        = odd_reg;
        alive_next      = alive_reg;
        uuid_low_next   = uuid_low_reg;
        record_hit_next = record_hit_reg;
        committed_next  = committed_reg;
        hit_now         = record_hit_reg;

        case (phase_reg)
            PH_LEN: begin
                if (step.data_byte == 8'd0) begin
                    phase_next = PH_STOP;
                end else begin
                    bytes_left_next = step.data_byte;
                    phase_next      = PH_TYPE;
                end
            end
            PH_TYPE: begin
                bytes_left_next = bytes_dec;
                if (step.data_byte == AD_NAME_SHORT || step.data_byte == AD_NAME_FULL) begin
                    kind_next = KIND_NAME;
                end else if (step.data_byte == AD_UUID16_INC ||
                             step.data_byte == AD_UUID16_ALL) begin
                    kind_next = KIND_UUID;
                end else begin
                    kind_next = KIND_OTHER;
                end
                pos_next        = '0;
                odd_next        = 1'b0;
                alive_next      = ALIVE_ALL;
                uuid_low_next   = 8'd0;
                record_hit_next = 1'b0;
                phase_next      = (bytes_dec == 8'd0) ? PH_LEN : PH_DATA;
            end
            PH_DATA: begin
                case (kind_reg)
                    KIND_NAME: begin
                        alive_next = name_res.alive;
                        hit_now    = record_hit_reg | name_res.hit;
                    end
                    KIND_UUID: begin
                        if (!odd_reg) begin
                            uuid_low_next = step.data_byte;
                        end else if ({step.data_byte, uuid_low_reg} == uuid_a ||
                                     {step.data_byte, uuid_low_reg} == uuid_b) begin
                            hit_now = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                record_hit_next = hit_now;
                if (pos_reg != POS_W'(PREFIX_MAX_LEN)) begin
                    pos_next = pos_reg + POS_W'(1);
                end
                odd_next        = ~odd_reg;
                bytes_left_next = bytes_dec;
                // Commit the record once its last byte is in
                if (bytes_dec == 8'd0) begin
                    committed_next = committed_reg | hit_now;
                    phase_next     = PH_LEN;
                end
            end
            default: begin
            end
        endcase

        matched = committed_next;

        // Restart for the next payload after the final byte
        if (step.last_byte) begin
            phase_next      = PH_LEN;
            kind_next       = KIND_OTHER;
            bytes_left_next = 8'd0;
            pos_next        = '0;
            odd_next        = 1'b0;
            alive_next      = ALIVE_ALL;
            uuid_low_next   = 8'd0;
            record_hit_next = 1'b0;
            committed_next  = 1'b0;
        end
    end

    // Hold parse state between bytes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_LEN;
            kind_reg       <= KIND_OTHER;
            bytes_left_reg <= 8'd0;
            pos_reg        <= '0;
            odd_reg        <= 1'b0;
            alive_reg      <= ALIVE_ALL;
            uuid_low_reg   <= 8'd0;
            record_hit_reg <= 1'b0;
            committed_reg  <= 1'b0;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            bytes_left_reg <= bytes_left_next;
            pos_reg        <= pos_next;
            odd_reg        <= odd_next;
            alive_reg      <= alive_next;
            uuid_low_reg   <= uuid_low_next;
            record_hit_reg <= record_hit_next;
            committed_reg  <= committed_next;
        end
    end

endmodule

FILE: src/ble_adv_serial_module_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_adv_serial_module_filter
// Flags advertising payloads from serial radio modules by name prefix or by
// 16-bit service UUID.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one payload byte per transaction, with s_last_byte
//   marking the final byte. The m_ channel carries one transaction per
//   payload, m_matched, issued for the final byte only.
//   Each byte lands in an input register and is parsed in the following
//   cycle, unless it is a final byte held by a pending result; the verdict
//   lands in the result register at the edge that parses the final byte.
//   One byte is accepted every cycle while no final byte waits on a
//   pending result; the rate is set by the single parse stage, which
//   updates the record state and compares all prefixes in parallel.
//   While m_valid waits for m_ready, non-final bytes keep flowing; a second
//   final byte waits in the input register until the result is taken.
//   Reset (aresetn low, synchronous) empties both registers, restarts the
//   record walk and loads the UUID registers with 0xFFE0 and 0xFFF0.
//   Write the UUID registers through cfg_wr_* only while no payload is in
//   flight.
// ----------------------------------------------------------------------------
module ble_adv_serial_module_filter (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_data_byte,
    input  logic                               s_last_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_matched,
    input  logic                               cfg_wr_en,
    input  logic [bleasf_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [bleasf_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import bleasf_pkg::*;

    logic         in_valid_reg, in_valid_next;
    bleasf_step_t in_step_reg;
    logic         out_valid_reg, out_valid_next;
    logic         out_matched_reg;
    logic [15:0]  uuid_a_reg, uuid_b_reg;

    logic out_free;
    logic consume;
    logic parse_matched;

    assign out_free = !out_valid_reg || m_ready;
    assign consume  = in_valid_reg && (!in_step_reg.last_byte || out_free);
    assign s_ready  = !in_valid_reg || consume;

    assign m_valid   = out_valid_reg;
    assign m_matched = out_matched_reg;

    bleasf_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (consume),
        .step    (in_step_reg),
        .uuid_a  (uuid_a_reg),
        .uuid_b  (uuid_b_reg),
        .matched (parse_matched)
    );

    // Input register occupancy
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    // Result register occupancy
    always_comb begin
        out_valid_next = out_valid_reg;
        if (consume && in_step_reg.last_byte) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture payloads
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_step_reg.data_byte <= s_data_byte;
            in_step_reg.last_byte <= s_last_byte;
        end
        if (consume && in_step_reg.last_byte) begin
            out_matched_reg <= parse_matched;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uuid_a_reg <= UUID_A_RESET;
            uuid_b_reg <= UUID_B_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_UUID_A: uuid_a_reg <= cfg_wr_data;
                CFG_UUID_B: uuid_b_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: src/bleasf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bleasf_checker
// Port-level checks for the serial module advertisement filter, bound to
// the top level.
// ----------------------------------------------------------------------------
module bleasf_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_matched
);

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Input side is free once reset is released
    a_ready_after_reset: assert property (@(posedge aclk) $rose(aresetn) |-> s_ready)
        else $error("not ready after reset");

    // With no result pending, bytes are never held off
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // A stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_matched))
        else $error("stalled result changed");

endmodule

bind ble_adv_serial_module_filter bleasf_checker u_bleasf_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_matched   (m_matched)
);
